// ===== rtl/ppt_pkg.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon test package
// Shared constants, types, command words and the multiply micro-op table.
// ----------------------------------------------------------------------------
package ppt_pkg;

  localparam int FIELD_WIDTH     = 32;
  localparam int DIST_WIDTH      = 32;
  localparam int MARGIN_WIDTH    = 31;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int MUL_DIGIT       = 8;
  localparam int IDX_WIDTH       = 4;
  localparam int APB_DATA_WIDTH  = 32;
  localparam int APB_ADDR_WIDTH  = 3;
  localparam int REG_IDX_WIDTH   = APB_ADDR_WIDTH - 2;

  localparam logic [REG_IDX_WIDTH-1:0] REG_MARGIN = '0;

  // Multiply micro-op indexes.
  localparam logic [IDX_WIDTH-1:0] MI_CROSS  = 4'd0;
  localparam logic [IDX_WIDTH-1:0] MI_DOT    = 4'd2;
  localparam logic [IDX_WIDTH-1:0] MI_LEN    = 4'd4;
  localparam logic [IDX_WIDTH-1:0] MI_LEN_END = 4'd5;
  localparam logic [IDX_WIDTH-1:0] MI_NEAR_A = 4'd6;
  localparam logic [IDX_WIDTH-1:0] MI_NEAR_A_END = 4'd7;
  localparam logic [IDX_WIDTH-1:0] MI_NEAR_B = 4'd8;
  localparam logic [IDX_WIDTH-1:0] MI_NEAR_B_END = 4'd9;
  localparam logic [IDX_WIDTH-1:0] MI_PROJ   = 4'd10;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE,
    S_MUL_GO,
    S_MUL_WAIT,
    S_DECIDE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    OP_WX,
    OP_WY,
    OP_DX,
    OP_DY,
    OP_EX,
    OP_EY,
    OP_CR
  } opnd_t;

  typedef enum logic [2:0] {
    TGT_NONE,
    TGT_CR,
    TGT_DOT,
    TGT_LEN2,
    TGT_NUM
  } tgt_t;

  typedef enum logic [1:0] {
    BR_NEAR_A,
    BR_NEAR_B,
    BR_PROJ
  } branch_t;

  typedef struct packed {
    opnd_t a;
    opnd_t b;
    logic  clear;
    logic  sub;
    tgt_t  tgt;
  } mul_op_t;

  typedef struct packed {
    logic                 load;
    logic                 start;
    logic                 edge_setup;
    logic                 edge_close;
    logic                 mul_start;
    logic [IDX_WIDTH-1:0] mul_idx;
    logic                 decide;
    logic                 div_start;
    logic                 sqrt_start;
    logic                 sqrt_from_div;
    logic                 emit;
    logic                 few;
  } cmd_t;

  typedef struct packed {
    logic    mul_done;
    logic    div_done;
    logic    sqrt_done;
    branch_t branch;
    logic    out_free;
  } stat_t;

  function automatic mul_op_t mul_op(input logic [IDX_WIDTH-1:0] idx);
    mul_op_t op;
    op = '{a: OP_WX, b: OP_WX, clear: 1'b1, sub: 1'b0, tgt: TGT_NONE};
    case (idx)
      4'd0:    op = '{a: OP_WX, b: OP_DY, clear: 1'b1, sub: 1'b0, tgt: TGT_NONE};
      4'd1:    op = '{a: OP_WY, b: OP_DX, clear: 1'b0, sub: 1'b1, tgt: TGT_CR};
      4'd2:    op = '{a: OP_WX, b: OP_DX, clear: 1'b1, sub: 1'b0, tgt: TGT_NONE};
      4'd3:    op = '{a: OP_WY, b: OP_DY, clear: 1'b0, sub: 1'b0, tgt: TGT_DOT};
      4'd4:    op = '{a: OP_DX, b: OP_DX, clear: 1'b1, sub: 1'b0, tgt: TGT_NONE};
      4'd5:    op = '{a: OP_DY, b: OP_DY, clear: 1'b0, sub: 1'b0, tgt: TGT_LEN2};
      4'd6:    op = '{a: OP_WX, b: OP_WX, clear: 1'b1, sub: 1'b0, tgt: TGT_NONE};
      4'd7:    op = '{a: OP_WY, b: OP_WY, clear: 1'b0, sub: 1'b0, tgt: TGT_NUM};
      4'd8:    op = '{a: OP_EX, b: OP_EX, clear: 1'b1, sub: 1'b0, tgt: TGT_NONE};
      4'd9:    op = '{a: OP_EY, b: OP_EY, clear: 1'b0, sub: 1'b0, tgt: TGT_NUM};
      4'd10:   op = '{a: OP_CR, b: OP_CR, clear: 1'b1, sub: 1'b0, tgt: TGT_NUM};
      default: op = '{a: OP_WX, b: OP_WX, clear: 1'b1, sub: 1'b0, tgt: TGT_NONE};
    endcase
    return op;
  endfunction

endpackage

// ===== rtl/ppt_in_if.sv =====
// ----------------------------------------------------------------------------
// Vertex input channel
// Valid/ready channel carrying one polygon vertex word.
// ----------------------------------------------------------------------------
interface ppt_in_if;
  import ppt_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [FIELD_WIDTH-1:0] point_x;
  logic signed [FIELD_WIDTH-1:0] point_y;
  logic signed [FIELD_WIDTH-1:0] vertex_x;
  logic signed [FIELD_WIDTH-1:0] vertex_y;
  logic                          first_vertex;
  logic                          last_vertex;

  modport source (
    output valid, point_x, point_y, vertex_x, vertex_y, first_vertex, last_vertex,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, vertex_x, vertex_y, first_vertex, last_vertex,
    output ready
  );
endinterface

// ===== rtl/ppt_out_if.sv =====
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying one polygon test result word.
// ----------------------------------------------------------------------------
interface ppt_out_if;
  import ppt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  inside_res;
  logic [DIST_WIDTH-1:0] min_distance;
  logic                  near_edge;
  logic                  accepted;
  logic                  too_few_vertices;

  modport source (
    output valid, inside_res, min_distance, near_edge, accepted, too_few_vertices,
    input  ready
  );
  modport sink (
    input  valid, inside_res, min_distance, near_edge, accepted, too_few_vertices,
    output ready
  );
endinterface

// ===== rtl/ppt_mul.sv =====
// ----------------------------------------------------------------------------
// Digit-serial multiplier
// Unsigned multiply, one digit of the second operand per cycle.
// ----------------------------------------------------------------------------
module ppt_mul #(
  parameter int WIDTH = 35
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [WIDTH-1:0]   a,
  input  logic [WIDTH-1:0]   b,
  output logic               done,
  output logic [2*WIDTH-1:0] prod
);
  import ppt_pkg::*;

  localparam int PW = 2 * WIDTH;

  logic [PW-1:0]    ma;
  logic [WIDTH-1:0] mb;
  logic [WIDTH-1:0] mb_shift;
  logic [PW-1:0]    pp;
  logic             busy;

  assign mb_shift = mb >> MUL_DIGIT;
  assign pp       = ma * PW'(mb[MUL_DIGIT-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && mb_shift == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma   <= PW'(a);
      mb   <= b;
      prod <= '0;
    end else if (busy) begin
      prod <= prod + pp;
      ma   <= ma << MUL_DIGIT;
      mb   <= mb_shift;
    end
  end
endmodule

// ===== rtl/ppt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Polygon test controller
// Sequences vertex loads, edge evaluation steps and result emission.
// ----------------------------------------------------------------------------
module ppt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_first,
  input  logic          in_last,
  output logic          in_ready,
  input  ppt_pkg::stat_t stat,
  output ppt_pkg::cmd_t  cmd
);
  import ppt_pkg::*;

  state_t               state;
  state_t               state_next;
  logic [1:0]           seen;
  logic [1:0]           seen_next;
  logic                 last_r;
  logic                 last_r_next;
  logic                 closing;
  logic                 closing_next;
  logic                 use_div;
  logic                 use_div_next;
  logic [IDX_WIDTH-1:0] idx;
  logic [IDX_WIDTH-1:0] idx_next;
  logic                 start_item;

  assign start_item = in_first || seen == 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      seen    <= 2'd0;
      last_r  <= 1'b0;
      closing <= 1'b0;
      use_div <= 1'b0;
      idx     <= '0;
    end else begin
      state   <= state_next;
      seen    <= seen_next;
      last_r  <= last_r_next;
      closing <= closing_next;
      use_div <= use_div_next;
      idx     <= idx_next;
    end
  end

  always_comb begin
    state_next   = state;
    seen_next    = seen;
    last_r_next  = last_r;
    closing_next = closing;
    use_div_next = use_div;
    idx_next     = idx;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.mul_idx       = idx;
    cmd.edge_close    = closing;
    cmd.sqrt_from_div = use_div;
    cmd.start         = start_item;
    cmd.few           = seen != 2'd3;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (start_item) begin
            seen_next  = 2'd1;
            state_next = in_last ? S_EMIT : S_IDLE;
          end else begin
            seen_next    = (seen == 2'd3) ? 2'd3 : seen + 2'd1;
            last_r_next  = in_last;
            closing_next = 1'b0;
            state_next   = S_EDGE;
          end
        end
      end
      S_EDGE: begin
        cmd.edge_setup = 1'b1;
        idx_next       = MI_CROSS;
        state_next     = S_MUL_GO;
      end
      S_MUL_GO: begin
        cmd.mul_start = 1'b1;
        state_next    = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (stat.mul_done) begin
          case (idx)
            MI_LEN_END: state_next = S_DECIDE;
            MI_NEAR_A_END, MI_NEAR_B_END: begin
              use_div_next = 1'b0;
              state_next   = S_SQRT_GO;
            end
            MI_PROJ: state_next = S_DIV_GO;
            default: begin
              idx_next   = idx + IDX_WIDTH'(1);
              state_next = S_MUL_GO;
            end
          endcase
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        case (stat.branch)
          BR_NEAR_A: idx_next = MI_NEAR_A;
          BR_NEAR_B: idx_next = MI_NEAR_B;
          default:   idx_next = MI_PROJ;
        endcase
        state_next = S_MUL_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (stat.div_done) begin
          use_div_next = 1'b1;
          state_next   = S_SQRT_GO;
        end
      end
      S_SQRT_GO: begin
        cmd.sqrt_start = 1'b1;
        state_next     = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (stat.sqrt_done) begin
          if (last_r && !closing) begin
            closing_next = 1'b1;
            state_next   = S_EDGE;
          end else if (last_r) begin
            state_next = S_EMIT;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          seen_next  = 2'd0;
          last_r_next = 1'b0;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ===== rtl/ppt_datapath.sv =====
// ----------------------------------------------------------------------------
// Polygon test datapath
// Vertex state, edge differences, exact products, division, square root and
// the result register.
// ----------------------------------------------------------------------------
module ppt_datapath #(
  parameter int COORD_WIDTH = ppt_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ppt_pkg::cmd_t                       cmd,
  output ppt_pkg::stat_t                      stat,
  input  logic signed [ppt_pkg::FIELD_WIDTH-1:0] point_x,
  input  logic signed [ppt_pkg::FIELD_WIDTH-1:0] point_y,
  input  logic signed [ppt_pkg::FIELD_WIDTH-1:0] vertex_x,
  input  logic signed [ppt_pkg::FIELD_WIDTH-1:0] vertex_y,
  input  logic [ppt_pkg::MARGIN_WIDTH-1:0]    margin,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                inside_res,
  output logic [ppt_pkg::DIST_WIDTH-1:0]      min_distance,
  output logic                                near_edge,
  output logic                                accepted,
  output logic                                too_few_vertices
);
  import ppt_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;
  localparam int SW = 2 * W + 3;
  localparam int AW = 2 * SW;
  localparam int QW = 2 * W + 2;
  localparam int CW = $clog2(QW + 1);

  function automatic logic signed [W-1:0] coord(input logic signed [FIELD_WIDTH-1:0] f);
    logic [2*FIELD_WIDTH-1:0] e;
    e = {{FIELD_WIDTH{f[FIELD_WIDTH-1]}}, f};
    return e[W-1:0];
  endfunction

  logic signed [W-1:0]  qx, qy, fx, fy, px, py, vx, vy;
  logic signed [W-1:0]  ax, ay, bx, by;
  logic signed [DW-1:0] wx, wy, dx, dy, ex, ey;
  logic                 straddle;
  logic                 a_above;
  logic                 inside_t;
  logic [DIST_WIDTH-1:0] best;

  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] acc_new;
  logic signed [AW-1:0] acc_base;
  logic signed [SW-1:0] cr, dot, len2;
  logic [AW-1:0]        num;

  mul_op_t              op;
  logic signed [SW-1:0] sa, sb;
  logic [SW-1:0]        ma, mb;
  logic                 psign;
  logic                 mul_done;
  logic [AW-1:0]        prod;

  logic [QW-1:0]        rem, nlo, quo, den;
  logic [QW:0]          dt;
  logic                 dge;
  logic [CW-1:0]        dcnt;
  logic                 dbusy, ddone;

  logic [QW-1:0]        sx, sr, sbit, st;
  logic                 sbusy, sdone;
  logic [DIST_WIDTH-1:0] seg_dist;
  logic                 near;
  branch_t              branch;

  assign ax = cmd.edge_close ? vx : px;
  assign ay = cmd.edge_close ? vy : py;
  assign bx = cmd.edge_close ? fx : vx;
  assign by = cmd.edge_close ? fy : vy;

  // Operand selection for the shared multiplier.
  assign op = mul_op(cmd.mul_idx);

  always_comb begin
    case (op.a)
      OP_WX:   sa = SW'(wx);
      OP_WY:   sa = SW'(wy);
      OP_DX:   sa = SW'(dx);
      OP_DY:   sa = SW'(dy);
      OP_EX:   sa = SW'(ex);
      OP_EY:   sa = SW'(ey);
      OP_CR:   sa = cr;
      default: sa = '0;
    endcase
    case (op.b)
      OP_WX:   sb = SW'(wx);
      OP_WY:   sb = SW'(wy);
      OP_DX:   sb = SW'(dx);
      OP_DY:   sb = SW'(dy);
      OP_EX:   sb = SW'(ex);
      OP_EY:   sb = SW'(ey);
      OP_CR:   sb = cr;
      default: sb = '0;
    endcase
  end

  assign ma = sa[SW-1] ? SW'(-sa) : SW'(sa);
  assign mb = sb[SW-1] ? SW'(-sb) : SW'(sb);

  ppt_mul #(.WIDTH(SW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (ma),
    .b     (mb),
    .done  (mul_done),
    .prod  (prod)
  );

  assign acc_base = op.clear ? '0 : acc;
  assign acc_new  = (op.sub ^ psign) ? acc_base - signed'(prod) : acc_base + signed'(prod);

  always_comb begin
    if (dot <= 0) begin
      branch = BR_NEAR_A;
    end else if (dot >= len2) begin
      branch = BR_NEAR_B;
    end else begin
      branch = BR_PROJ;
    end
  end

  assign dt  = {rem, nlo[QW-1]};
  assign dge = dt >= {1'b0, den};
  assign st  = sr + sbit;

  assign seg_dist = (|sr[QW-1:DIST_WIDTH]) ? '1 : sr[DIST_WIDTH-1:0];
  assign near     = (margin != '0) && (best <= DIST_WIDTH'(margin));

  assign stat.mul_done  = mul_done;
  assign stat.div_done  = ddone;
  assign stat.sqrt_done = sdone;
  assign stat.branch    = branch;
  assign stat.out_free  = !out_valid || out_ready;

  // Vertex and edge state.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vx <= coord(vertex_x);
      vy <= coord(vertex_y);
      if (cmd.start) begin
        qx <= coord(point_x);
        qy <= coord(point_y);
        fx <= coord(vertex_x);
        fy <= coord(vertex_y);
        px <= coord(vertex_x);
        py <= coord(vertex_y);
      end
    end
    if (cmd.edge_setup) begin
      wx       <= DW'(qx) - DW'(ax);
      wy       <= DW'(qy) - DW'(ay);
      dx       <= DW'(bx) - DW'(ax);
      dy       <= DW'(by) - DW'(ay);
      ex       <= DW'(qx) - DW'(bx);
      ey       <= DW'(qy) - DW'(by);
      straddle <= (by > qy) != (ay > qy);
      a_above  <= ay > by;
      if (!cmd.edge_close) begin
        px <= vx;
        py <= vy;
      end
    end
    if (cmd.mul_start) begin
      psign <= sa[SW-1] ^ sb[SW-1];
    end
    if (mul_done) begin
      acc <= acc_new;
      case (op.tgt)
        TGT_CR:   cr   <= acc_new[SW-1:0];
        TGT_DOT:  dot  <= acc_new[SW-1:0];
        TGT_LEN2: len2 <= acc_new[SW-1:0];
        TGT_NUM:  num  <= acc_new;
        default:  ;
      endcase
    end
  end

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      ddone <= 1'b0;
    end else begin
      ddone <= 1'b0;
      if (cmd.div_start) begin
        dbusy <= 1'b1;
      end else if (dbusy && dcnt == CW'(QW - 1)) begin
        dbusy <= 1'b0;
        ddone <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem  <= num[2*QW-1:QW];
      nlo  <= num[QW-1:0];
      den  <= len2[QW-1:0];
      dcnt <= '0;
    end else if (dbusy) begin
      rem  <= dge ? QW'(dt - {1'b0, den}) : dt[QW-1:0];
      quo  <= {quo[QW-2:0], dge};
      nlo  <= nlo << 1;
      dcnt <= dcnt + CW'(1);
    end
  end

  // Integer square root, one result bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      sbusy <= 1'b0;
      sdone <= 1'b0;
    end else begin
      sdone <= 1'b0;
      if (cmd.sqrt_start) begin
        sbusy <= 1'b1;
      end else if (sbusy && sbit == QW'(1)) begin
        sbusy <= 1'b0;
        sdone <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      sx   <= cmd.sqrt_from_div ? quo : num[QW-1:0];
      sr   <= '0;
      sbit <= QW'(1) << (QW - 2);
    end else if (sbusy) begin
      if (sx >= st) begin
        sx <= sx - st;
        sr <= (sr >> 1) + sbit;
      end else begin
        sr <= sr >> 1;
      end
      sbit <= sbit >> 2;
    end
  end

  // Polygon accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_t <= 1'b0;
      best     <= '1;
    end else begin
      if (cmd.load && cmd.start) begin
        inside_t <= 1'b0;
        best     <= '1;
      end
      if (cmd.decide && straddle && (a_above ? (cr > 0) : (cr < 0))) begin
        inside_t <= !inside_t;
      end
      if (sdone && seg_dist < best) begin
        best <= seg_dist;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      inside_res       <= inside_t && !cmd.few;
      min_distance     <= best;
      near_edge        <= near;
      accepted         <= (inside_t && !cmd.few) || near;
      too_few_vertices <= cmd.few;
    end
  end
endmodule

// ===== rtl/polygon_point_test_with_margin_core.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon test with edge margin
// A vertex word that opens a polygon is loaded without an edge; any other runs one
// edge, and the last vertex also the closing edge and then the result word.
// An edge is 7 or 8 products, a division for an interior foot point and a root.
// Synchronous reset clears control state, margin, the inside flag and the result
// valid, and sets the best distance to all ones.
// ----------------------------------------------------------------------------
module polygon_point_test_with_margin_core #(
  parameter int COORD_WIDTH = ppt_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  ppt_in_if.sink                              in_ch,
  ppt_out_if.source                           out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ppt_pkg::APB_ADDR_WIDTH-1:0]  paddr,
  input  logic [ppt_pkg::APB_DATA_WIDTH-1:0]  pwdata,
  output logic [ppt_pkg::APB_DATA_WIDTH-1:0]  prdata,
  output logic                                pready
);
  import ppt_pkg::*;

  cmd_t                    cmd;
  stat_t                   stat;
  logic [MARGIN_WIDTH-1:0] margin;
  logic                    reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = paddr[APB_ADDR_WIDTH-1:2] == REG_MARGIN;

  always_ff @(posedge clk) begin
    if (rst) begin
      margin <= '0;
    end else if (psel && penable && pwrite && reg_hit) begin
      margin <= pwdata[MARGIN_WIDTH-1:0];
    end
  end

  assign prdata = reg_hit ? APB_DATA_WIDTH'(margin) : '0;

  ppt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_first (in_ch.first_vertex),
    .in_last  (in_ch.last_vertex),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ppt_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .point_x          (in_ch.point_x),
    .point_y          (in_ch.point_y),
    .vertex_x         (in_ch.vertex_x),
    .vertex_y         (in_ch.vertex_y),
    .margin           (margin),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .inside_res       (out_ch.inside_res),
    .min_distance     (out_ch.min_distance),
    .near_edge        (out_ch.near_edge),
    .accepted         (out_ch.accepted),
    .too_few_vertices (out_ch.too_few_vertices)
  );
endmodule
